### hdl/cffsa_pkg.sv
// ----------------------------------------------------------------------------
// cffsa_pkg
// Shared types and constants for the circular first-free slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cffsa_pkg;

    localparam int SLOT_W     = 10;
    localparam int CFG_W      = 11;
    localparam int SLOT_SPACE = 1024;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

    typedef struct packed {
        func_t             func;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic              store_full;
    } rsp_t;

endpackage

`default_nettype wire

### hdl/cffsa_first_free.sv
// ----------------------------------------------------------------------------
// cffsa_first_free
// Lowest-set-bit finder: isolates the lowest set bit and encodes its position.
// ----------------------------------------------------------------------------
`default_nettype none

module cffsa_first_free #(
    parameter int WIDTH = 1024
) (
    input  logic [WIDTH-1:0]         vec,
    output logic                     found,
    output logic [$clog2(WIDTH)-1:0] index
);

    localparam int IDX_W = $clog2(WIDTH);

    logic [WIDTH-1:0] lowest;

    // isolate the lowest set bit (two's complement trick)
    assign lowest = vec & (~vec + WIDTH'(1));
    assign found  = |vec;

    always_comb
    begin
        index = '0;
        for (int i = 0; i < WIDTH; i++)
        begin
            if (lowest[i])
            begin
                index = index | IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/circular_first_free_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// circular_first_free_slot_allocator_core
// Occupancy bitmap with circular first-free allocation and release.
// ----------------------------------------------------------------------------
// One request is taken per cycle while results are taken. A request waits
// in the input register, where the search over the whole occupancy bitmap
// (two lowest-set finders, one from the hint upwards and one from slot zero)
// runs; the map update and the result register load when it advances, so the
// next request always sees the updated map. A request passes through the
// input register and then the result register. Releases give no result. The
// bitmap is held in flip-flops and cleared at once by reset, so no clearing
// pass is needed.
// The slot count register must only be written while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_first_free_slot_allocator_core
    import cffsa_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,

    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,

    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int DEPTH = (MAX_SLOTS < SLOT_SPACE) ? MAX_SLOTS : SLOT_SPACE;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [CFG_W-1:0] cfg_reg;
    req_t             req_reg;
    logic             req_valid_reg;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [DEPTH-1:0] map_reg, map_next;

    logic [CW-1:0]    count;
    logic             slot_in_range;
    logic [IW-1:0]    start;
    logic [IW-1:0]    slot_idx;
    logic [DEPTH-1:0] free_vec;
    logic [DEPTH-1:0] upper_mask;
    logic             upper_found, any_found;
    logic [IW-1:0]    upper_idx, any_idx;
    logic             grant_found;
    logic [IW-1:0]    grant_idx;
    logic             advance;

    // -------------------------------------------------------------------------
    // Effective slot count and free vector
    // -------------------------------------------------------------------------
    assign count = (cfg_reg > CFG_W'(DEPTH)) ? CW'(DEPTH) : cfg_reg[CW-1:0];

    assign slot_in_range = CFG_W'(req_reg.slot) < CFG_W'(count);
    assign slot_idx      = req_reg.slot[IW-1:0];
    assign start         = slot_in_range ? slot_idx : '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_bits
        assign free_vec[i]   = !map_reg[i] && (CW'(i) < count);
        assign upper_mask[i] = IW'(i) >= start;
    end

    cffsa_first_free #(
        .WIDTH (DEPTH)
    ) u_find_upper (
        .vec   (free_vec & upper_mask),
        .found (upper_found),
        .index (upper_idx)
    );

    cffsa_first_free #(
        .WIDTH (DEPTH)
    ) u_find_any (
        .vec   (free_vec),
        .found (any_found),
        .index (any_idx)
    );

    // wrap to the lowest free slot when nothing is free at or above the hint
    assign grant_found = upper_found || any_found;
    assign grant_idx   = upper_found ? upper_idx : any_idx;

    // -------------------------------------------------------------------------
    // Handshake
    // -------------------------------------------------------------------------
    assign advance   = req_valid_reg &&
                       ((req_reg.func == FUNC_RELEASE) || !rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // -------------------------------------------------------------------------
    // Map update and result
    // -------------------------------------------------------------------------
    always_comb
    begin
        map_next       = map_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (advance)
        begin
            if (req_reg.func == FUNC_RELEASE)
            begin
                if (slot_in_range)
                begin
                    map_next[slot_idx] = 1'b0;
                end
            end
            else
            begin
                rsp_valid_next = 1'b1;
                if (grant_found)
                begin
                    map_next[grant_idx]   = 1'b1;
                    rsp_next.granted_slot = SLOT_W'(grant_idx);
                    rsp_next.store_full   = 1'b0;
                end
                else
                begin
                    rsp_next.granted_slot = '0;
                    rsp_next.store_full   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            map_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            rsp_valid_reg <= rsp_valid_next;
            map_reg       <= map_next;
        end
    end

    // payload registers: hold unless a transfer or a new result arrives
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire
